### src/qrs_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared result codes, field widths and the sideband structs that ride along
// with each item through the square root and divider pipelines.
// ----------------------------------------------------------------------------
package qrs_pkg;

  typedef enum logic [1:0] {
    KIND_DISTINCT = 2'd0,
    KIND_REPEATED = 2'd1,
    KIND_COMPLEX  = 2'd2,
    KIND_DEGEN    = 2'd3
  } root_kind_e;

  localparam int CoefW = 16;  // Q8.8 coefficient
  localparam int DiscW = 34;  // Q18.16 discriminant
  localparam int MagW  = 33;  // magnitude of the discriminant
  localparam int RadW  = 64;  // radicand, magnitude shifted up by 30
  localparam int RootW = 32;  // floor square root of the radicand
  localparam int NbW   = 32;  // -b scaled by 2^15
  localparam int NumW  = 34;  // numerator magnitude
  localparam int DivW  = 16;  // divisor magnitude
  localparam int ValW  = 40;  // Q24.16 result

  localparam int SqrtShift = 30;
  localparam int NumShift  = 15;

  typedef struct packed {
    root_kind_e               kind;
    logic signed [DiscW-1:0]  disc;
    logic signed [NbW-1:0]    nb;
    logic signed [CoefW-1:0]  quad;
  } sq_side_t;

  typedef struct packed {
    root_kind_e               kind;
    logic signed [DiscW-1:0]  disc;
    logic                     neg_first;
    logic                     neg_second;
  } dv_side_t;

endpackage

### src/qrs_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root of the shifted discriminant magnitude,
// one result bit per register stage, with the item's sideband alongside.
// ----------------------------------------------------------------------------
module qrs_sqrt_pipe import qrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [MagW-1:0]  mag_i,
  input  sq_side_t         side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output sq_side_t         side_o
);

  localparam int Steps = RootW;
  localparam int RemW  = RootW + 2;
  localparam int RemNW = RootW + 4;

  logic             vld_q  [Steps+1];
  logic [RadW-1:0]  rad_q  [Steps+1];
  logic [RemW-1:0]  rem_q  [Steps+1];
  logic [RootW-1:0] root_q [Steps+1];
  sq_side_t         side_q [Steps+1];

  logic [RadW-1:0]  rad_d   [Steps];
  logic [RemW-1:0]  rem_d   [Steps];
  logic [RootW-1:0] root_d  [Steps];
  logic [RemNW-1:0] remn    [Steps];
  logic [RemNW-1:0] trial   [Steps];
  logic             ge      [Steps];

  // Each stage brings down the next two radicand bits and tries a one bit.
  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      remn[k]   = {rem_q[k], rad_q[k][RadW-1 -: 2]};
      trial[k]  = {2'b00, root_q[k], 2'b01};
      ge[k]     = (remn[k] >= trial[k]);
      rem_d[k]  = ge[k] ? RemW'(remn[k] - trial[k]) : remn[k][RemW-1:0];
      root_d[k] = {root_q[k][RootW-2:0], ge[k]};
      rad_d[k]  = {rad_q[k][RadW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Steps; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= Steps; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q[0]  <= {(RadW-MagW-SqrtShift)'(0), mag_i, SqrtShift'(0)};
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    side_q[0] <= side_i;
    for (int k = 1; k <= Steps; k++) begin
      rad_q[k]  <= rad_d[k-1];
      rem_q[k]  <= rem_d[k-1];
      root_q[k] <= root_d[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = vld_q[Steps];
  assign root_o  = root_q[Steps];
  assign side_o  = side_q[Steps];

endmodule

### src/qrs_div_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined dual-lane divider
// Restoring division of two numerator magnitudes by one shared divisor
// magnitude, one quotient bit per register stage in each lane.
// ----------------------------------------------------------------------------
module qrs_div_pipe import qrs_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_first_i,
  input  logic [NumW-1:0] num_second_i,
  input  logic [DivW-1:0] divisor_i,
  input  dv_side_t        side_i,
  output logic            valid_o,
  output logic [NumW-1:0] quot_first_o,
  output logic [NumW-1:0] quot_second_o,
  output dv_side_t        side_o
);

  localparam int Steps = NumW;

  logic            vld_q  [Steps+1];
  logic [NumW-1:0] wk1_q  [Steps+1];
  logic [NumW-1:0] wk2_q  [Steps+1];
  logic [DivW-1:0] rm1_q  [Steps+1];
  logic [DivW-1:0] rm2_q  [Steps+1];
  logic [DivW-1:0] dvs_q  [Steps+1];
  dv_side_t        side_q [Steps+1];

  logic [DivW:0]   sh1 [Steps];
  logic [DivW:0]   sh2 [Steps];
  logic            ge1 [Steps];
  logic            ge2 [Steps];
  logic [DivW-1:0] rm1_d [Steps];
  logic [DivW-1:0] rm2_d [Steps];
  logic [NumW-1:0] wk1_d [Steps];
  logic [NumW-1:0] wk2_d [Steps];

  // The work register shifts numerator bits out at the top and quotient
  // bits in at the bottom.
  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      sh1[k]   = {rm1_q[k], wk1_q[k][NumW-1]};
      sh2[k]   = {rm2_q[k], wk2_q[k][NumW-1]};
      ge1[k]   = (sh1[k] >= {1'b0, dvs_q[k]});
      ge2[k]   = (sh2[k] >= {1'b0, dvs_q[k]});
      rm1_d[k] = ge1[k] ? DivW'(sh1[k] - {1'b0, dvs_q[k]}) : sh1[k][DivW-1:0];
      rm2_d[k] = ge2[k] ? DivW'(sh2[k] - {1'b0, dvs_q[k]}) : sh2[k][DivW-1:0];
      wk1_d[k] = {wk1_q[k][NumW-2:0], ge1[k]};
      wk2_d[k] = {wk2_q[k][NumW-2:0], ge2[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= Steps; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 1; k <= Steps; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    wk1_q[0]  <= num_first_i;
    wk2_q[0]  <= num_second_i;
    rm1_q[0]  <= '0;
    rm2_q[0]  <= '0;
    dvs_q[0]  <= divisor_i;
    side_q[0] <= side_i;
    for (int k = 1; k <= Steps; k++) begin
      wk1_q[k]  <= wk1_d[k-1];
      wk2_q[k]  <= wk2_d[k-1];
      rm1_q[k]  <= rm1_d[k-1];
      rm2_q[k]  <= rm2_d[k-1];
      dvs_q[k]  <= dvs_q[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o       = vld_q[Steps];
  assign quot_first_o  = wk1_q[Steps];
  assign quot_second_o = wk2_q[Steps];
  assign side_o        = side_q[Steps];

endmodule

### src/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// Quadratic root solver
// Fully pipelined fixed-point solver for a*x^2 + b*x + c = 0.
// ----------------------------------------------------------------------------
// done_o rises once an item has passed stage 1, stage 2, the square root,
// the divider and the output register. Throughput: one item per clock
// cycle; busy is always low. The depth is set by the square root (33 register
// stages) and the divider (35 register stages). Reset clears every valid
// bit, so no result strobes after reset until an item has passed the whole
// pipeline. The receiver cannot stall.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CoefW-1:0] coef_quad_i,
  input  logic signed [CoefW-1:0] coef_lin_i,
  input  logic signed [CoefW-1:0] coef_const_i,
  output logic                    done_o,
  output logic [1:0]              root_kind_o,
  output logic signed [DiscW-1:0] discriminant_o,
  output logic signed [ValW-1:0]  first_value_o,
  output logic signed [ValW-1:0]  second_value_o
);

  // Every stage advances each cycle and nothing waits on the receiver, so
  // an item is taken whenever start is high.
  assign busy = 1'b0;

  // Stage 1: the two 16x16 products.
  logic                    v1_q;
  logic signed [CoefW-1:0] a1_q, b1_q;
  logic signed [31:0]      bb_q, ac_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= coef_quad_i;
    b1_q <= coef_lin_i;
    bb_q <= 32'(coef_lin_i) * 32'(coef_lin_i);
    ac_q <= 32'(coef_quad_i) * 32'(coef_const_i);
  end

  // Stage 2: the exact discriminant, the scaled -b numerator and the class.
  logic                    v2_q;
  logic signed [DiscW-1:0] disc_d;
  logic signed [NbW-1:0]   nb_d;
  root_kind_e              kind_d;
  sq_side_t                side2_q;

  always_comb begin
    disc_d = DiscW'(bb_q) - (DiscW'(ac_q) <<< 2);
    nb_d   = -(NbW'(b1_q) <<< NumShift);
    if (a1_q == '0) begin
      kind_d = KIND_DEGEN;
    end else if (disc_d[DiscW-1]) begin
      kind_d = KIND_COMPLEX;
    end else if (disc_d == '0) begin
      kind_d = KIND_REPEATED;
    end else begin
      kind_d = KIND_DISTINCT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q.kind <= kind_d;
    side2_q.disc <= disc_d;
    side2_q.nb   <= nb_d;
    side2_q.quad <= a1_q;
  end

  // Square root of |disc| * 2^30, taken in the sqrt pipeline.
  logic [DiscW-1:0] disc_abs;
  logic             vs;
  logic [RootW-1:0] root_s;
  sq_side_t         side_s;

  assign disc_abs = side2_q.disc[DiscW-1] ? DiscW'(-side2_q.disc) : side2_q.disc;

  qrs_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .mag_i   (disc_abs[MagW-1:0]),
    .side_i  (side2_q),
    .valid_o (vs),
    .root_o  (root_s),
    .side_o  (side_s)
  );

  // Numerators for the two results. A complex pair divides -b and the root
  // separately; real roots divide -b plus and minus the root. When the
  // discriminant is zero the root is zero, so both real forms agree.
  localparam int NW = NumW + 1;

  logic signed [NW-1:0] nb_x, s_x, n1, n2;
  logic [NW-1:0]        n1_abs, n2_abs;
  logic [CoefW-1:0]     a_abs;
  dv_side_t             side_dv;

  always_comb begin
    nb_x = NW'(side_s.nb);
    s_x  = NW'({1'b0, root_s});
    if (side_s.kind == KIND_COMPLEX) begin
      n1 = nb_x;
      n2 = s_x;
    end else begin
      n1 = nb_x + s_x;
      n2 = nb_x - s_x;
    end
    n1_abs = n1[NW-1] ? NW'(-n1) : n1;
    n2_abs = n2[NW-1] ? NW'(-n2) : n2;
    a_abs  = side_s.quad[CoefW-1] ? CoefW'(-side_s.quad) : side_s.quad;
    side_dv.kind       = side_s.kind;
    side_dv.disc       = side_s.disc;
    side_dv.neg_first  = n1[NW-1] ^ side_s.quad[CoefW-1];
    side_dv.neg_second = n2[NW-1] ^ side_s.quad[CoefW-1];
  end

  logic            vd;
  logic [NumW-1:0] q1, q2;
  dv_side_t        side_o_dv;

  qrs_div_pipe u_div (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (vs),
    .num_first_i   (n1_abs[NumW-1:0]),
    .num_second_i  (n2_abs[NumW-1:0]),
    .divisor_i     (a_abs[DivW-1:0]),
    .side_i        (side_dv),
    .valid_o       (vd),
    .quot_first_o  (q1),
    .quot_second_o (q2),
    .side_o        (side_o_dv)
  );

  // Output stage: restore the signs (truncation toward zero) and force the
  // degenerate case, whose division by zero means nothing, to zero roots.
  logic signed [ValW-1:0] val1_d, val2_d;
  logic                   done_q;
  logic [1:0]             kind_q;
  logic signed [DiscW-1:0] disc_q;
  logic signed [ValW-1:0] val1_q, val2_q;

  always_comb begin
    val1_d = side_o_dv.neg_first  ? -ValW'(q1) : ValW'(q1);
    val2_d = side_o_dv.neg_second ? -ValW'(q2) : ValW'(q2);
    if (side_o_dv.kind == KIND_DEGEN) begin
      val1_d = '0;
      val2_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= side_o_dv.kind;
    disc_q <= side_o_dv.disc;
    val1_q <= val1_d;
    val2_q <= val2_d;
  end

  assign done_o         = done_q;
  assign root_kind_o    = kind_q;
  assign discriminant_o = disc_q;
  assign first_value_o  = val1_q;
  assign second_value_o = val2_q;

endmodule
